### design/vrbm_pkg.sv
package vrbm_pkg;

  // Access kinds and widths
  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Result error codes
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_UNMAPPED   = 2'd1;
  localparam logic [1:0] ERR_ARM7_WRITE = 2'd2;

  // Bank numbering, A..I
  localparam int BANK_A = 0;
  localparam int BANK_B = 1;
  localparam int BANK_C = 2;
  localparam int BANK_D = 3;
  localparam int BANK_E = 4;
  localparam int BANK_F = 5;
  localparam int BANK_G = 6;
  localparam int BANK_H = 7;
  localparam int BANK_I = 8;
  localparam int NUM_BANKS = 9;

  // Master select codes
  localparam logic [2:0] MST_BG  = 3'd1;
  localparam logic [2:0] MST_OBJ = 3'd2;
  localparam logic [2:0] MST_ALT = 3'd4;

  // Address regions (bits 31:21; LCDC_HI matches bits 31:20)
  localparam logic [10:0] REGION_BG_A  = 11'h030;
  localparam logic [10:0] REGION_BG_B  = 11'h031;
  localparam logic [10:0] REGION_OBJ_A = 11'h032;
  localparam logic [10:0] REGION_OBJ_B = 11'h033;
  localparam logic [11:0] LCDC_HI      = 12'h068;
  localparam logic [5:0]  LCDC_SLOTS   = 6'd41;

  // Bank word depths
  localparam int DEPTH_LARGE = 32768;
  localparam int DEPTH_E     = 16384;
  localparam int DEPTH_H     = 8192;
  localparam int DEPTH_SMALL = 4096;

  localparam int DATA_W = 32;

  typedef struct packed {
    logic [NUM_BANKS-1:0] hits;
    logic [1:0]           err;
    logic [1:0]           status;
    logic [3:0]           be;
    logic [DATA_W-1:0]    wdata;
  } dec_t;

endpackage

### design/vrbm_ram.sv
module vrbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [WIDTH/8-1:0]       be,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < WIDTH/8; i++) begin
        if (we && be[i]) begin
          mem[addr][8*i +: 8] <= wdata[8*i +: 8];
        end
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/vrbm_decode.sv
module vrbm_decode (
  input  logic                      cmd,
  input  logic [1:0]                access_size,
  input  logic [31:0]               address,
  input  logic [31:0]               write_data,
  input  logic                      arm7_window,
  input  logic [31:0]               ctrl_low,
  input  logic [39:0]               ctrl_high,
  output vrbm_pkg::dec_t            dec
);

  logic [71:0] ctrl_all;
  logic [vrbm_pkg::NUM_BANKS-1:0] en;
  logic [2:0] mst [vrbm_pkg::NUM_BANKS];
  logic [1:0] ofs [vrbm_pkg::NUM_BANKS];
  logic [5:0] slot;
  logic [3:0] lbank;
  logic [vrbm_pkg::NUM_BANKS-1:0] hits;
  logic [1:0]  err;
  logic [1:0]  status;
  logic [3:0]  be;
  logic [31:0] wdata;

  assign ctrl_all = {ctrl_high, ctrl_low};
  assign slot     = address[19:14];

  always_comb begin
    for (int b = 0; b < vrbm_pkg::NUM_BANKS; b++) begin
      en[b]  = ctrl_all[8*b + 7];
      mst[b] = ctrl_all[8*b +: 3];
      ofs[b] = ctrl_all[8*b + 3 +: 2];
    end
  end

  // Fixed slot layout of the linear window
  always_comb begin
    if (slot < 6'd32)      lbank = {2'b00, slot[4:3]};
    else if (slot < 6'd36) lbank = 4'(vrbm_pkg::BANK_E);
    else if (slot == 6'd36) lbank = 4'(vrbm_pkg::BANK_F);
    else if (slot == 6'd37) lbank = 4'(vrbm_pkg::BANK_G);
    else if (slot < 6'd40) lbank = 4'(vrbm_pkg::BANK_H);
    else                   lbank = 4'(vrbm_pkg::BANK_I);
  end

  always_comb begin
    hits = '0;
    err  = vrbm_pkg::ERR_OK;
    if (arm7_window) begin
      if (cmd == vrbm_pkg::CMD_WRITE) begin
        err = vrbm_pkg::ERR_ARM7_WRITE;
      end else begin
        for (int b = vrbm_pkg::BANK_C; b <= vrbm_pkg::BANK_D; b++) begin
          hits[b] = en[b] && (ofs[b] == {1'b0, address[17]});
        end
      end
    end else begin
      case (address[31:21])
        vrbm_pkg::REGION_BG_A: begin
          for (int b = vrbm_pkg::BANK_A; b <= vrbm_pkg::BANK_D; b++) begin
            hits[b] = en[b] && mst[b] == vrbm_pkg::MST_BG
                      && address[20:17] == {2'b00, ofs[b]};
          end
          hits[vrbm_pkg::BANK_E] = en[vrbm_pkg::BANK_E]
              && mst[vrbm_pkg::BANK_E] == vrbm_pkg::MST_BG && address[20:16] == 5'd0;
          for (int b = vrbm_pkg::BANK_F; b <= vrbm_pkg::BANK_G; b++) begin
            hits[b] = en[b] && mst[b] == vrbm_pkg::MST_BG
                      && address[20:14] == {4'd0, ofs[b][1], 1'b0, ofs[b][0]};
          end
        end
        vrbm_pkg::REGION_BG_B: begin
          hits[vrbm_pkg::BANK_C] = en[vrbm_pkg::BANK_C]
              && mst[vrbm_pkg::BANK_C] == vrbm_pkg::MST_ALT && address[20:17] == 4'd0;
          hits[vrbm_pkg::BANK_H] = en[vrbm_pkg::BANK_H]
              && mst[vrbm_pkg::BANK_H] == vrbm_pkg::MST_BG && address[20:15] == 6'd0;
          hits[vrbm_pkg::BANK_I] = en[vrbm_pkg::BANK_I]
              && mst[vrbm_pkg::BANK_I] == vrbm_pkg::MST_BG && address[20:14] == 7'd2;
        end
        vrbm_pkg::REGION_OBJ_A: begin
          for (int b = vrbm_pkg::BANK_A; b <= vrbm_pkg::BANK_B; b++) begin
            hits[b] = en[b] && mst[b] == vrbm_pkg::MST_OBJ
                      && address[20:17] == {3'd0, ofs[b][0]};
          end
          hits[vrbm_pkg::BANK_E] = en[vrbm_pkg::BANK_E]
              && mst[vrbm_pkg::BANK_E] == vrbm_pkg::MST_OBJ && address[20:16] == 5'd0;
          for (int b = vrbm_pkg::BANK_F; b <= vrbm_pkg::BANK_G; b++) begin
            hits[b] = en[b] && mst[b] == vrbm_pkg::MST_OBJ
                      && address[20:14] == {4'd0, ofs[b][1], 1'b0, ofs[b][0]};
          end
        end
        vrbm_pkg::REGION_OBJ_B: begin
          hits[vrbm_pkg::BANK_D] = en[vrbm_pkg::BANK_D]
              && mst[vrbm_pkg::BANK_D] == vrbm_pkg::MST_ALT && address[20:17] == 4'd0;
          hits[vrbm_pkg::BANK_I] = en[vrbm_pkg::BANK_I]
              && mst[vrbm_pkg::BANK_I] == vrbm_pkg::MST_OBJ && address[20:14] == 7'd0;
        end
        default: begin
          if (address[31:20] == vrbm_pkg::LCDC_HI && slot < vrbm_pkg::LCDC_SLOTS) begin
            hits[lbank] = en[lbank];
          end else begin
            err = vrbm_pkg::ERR_UNMAPPED;
          end
        end
      endcase
    end
  end

  // Status of banks C and D in object mode
  assign status = {en[vrbm_pkg::BANK_D] && mst[vrbm_pkg::BANK_D] == vrbm_pkg::MST_OBJ,
                   en[vrbm_pkg::BANK_C] && mst[vrbm_pkg::BANK_C] == vrbm_pkg::MST_OBJ};

  // Byte lanes and replicated write data
  always_comb begin
    case (access_size)
      vrbm_pkg::SIZE_BYTE: begin
        be    = 4'b0001 << address[1:0];
        wdata = {4{write_data[7:0]}};
      end
      vrbm_pkg::SIZE_HALF: begin
        be    = address[1] ? 4'b1100 : 4'b0011;
        wdata = {2{write_data[15:0]}};
      end
      default: begin
        be    = 4'b1111;
        wdata = write_data;
      end
    endcase
  end

  assign dec = {hits, err, status, be, wdata};

endmodule

### design/video_ram_bank_mapper_unit.sv
// Video RAM bank mapper: one CPU request in, one result out.
// out_valid rises once a taken request has passed the input register and the
// bank RAM access with registered read data.
// Throughput: one request per cycle; a stalled result holds the input side.
// Reset (rst_n low, synchronous) clears the pipeline valids and the bank
// control registers, then a clearing pass zeroes the bank RAMs (in_stall high).
module video_ram_bank_mapper_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic        in_arm7_window,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [8:0]  out_bank_hits,
  output logic [1:0]  out_vram_status,
  output logic [1:0]  out_error_code,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Bank control registers
  logic [31:0] ctrl_low_r;
  logic [39:0] ctrl_high_r;

  // Clearing pass after reset
  logic        clr_r;
  logic [14:0] clr_addr_r;

  // Stage 1: captured request
  logic        v1_r;
  logic        cmd1_r;
  logic [1:0]  size1_r;
  logic [31:0] addr1_r;
  logic [31:0] wdata1_r;
  logic        a7_1_r;

  // Stage 2: result sideband, RAM read data lives inside the RAMs
  logic        v2_r;
  logic        wr2_r;
  logic [1:0]  size2_r;
  logic [1:0]  lane2_r;
  logic [8:0]  hits2_r;
  logic [1:0]  status2_r;
  logic [1:0]  err2_r;

  logic        adv;
  logic        take;
  vrbm_pkg::dec_t dec;
  logic [31:0] rd [vrbm_pkg::NUM_BANKS];
  logic [31:0] rd_or;
  logic [31:0] rd_sh;

  // Shared RAM port signals; the clearing pass overrides the request
  logic        ram_en;
  logic [3:0]  ram_be;
  logic [31:0] ram_wdata;
  logic [14:0] ram_addr;

  assign pready = 1'b1;
  assign prdata = paddr[3] ? {24'd0, ctrl_high_r} : {32'd0, ctrl_low_r};

  // Write on the access phase; address bit 3 picks the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_low_r  <= '0;
      ctrl_high_r <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) ctrl_high_r <= pwdata[39:0];
      else          ctrl_low_r  <= pwdata[31:0];
    end
  end

  // Sweep every word of the deepest bank once; smaller banks wrap and repeat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 15'd1;
      if (clr_addr_r == 15'(vrbm_pkg::DEPTH_LARGE - 1)) clr_r <= 1'b0;
    end
  end

  // Advance stage 1 whenever the result slot is free or being drained
  assign adv      = v1_r && (!v2_r || !out_stall);
  assign take     = !clr_r && (!v1_r || adv);
  assign in_stall = !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (take) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      cmd1_r   <= in_cmd;
      size1_r  <= in_access_size;
      addr1_r  <= in_address;
      wdata1_r <= in_write_data;
      a7_1_r   <= in_arm7_window;
    end
  end

  vrbm_decode u_decode (
    .cmd         (cmd1_r),
    .access_size (size1_r),
    .address     (addr1_r),
    .write_data  (wdata1_r),
    .arm7_window (a7_1_r),
    .ctrl_low    (ctrl_low_r),
    .ctrl_high   (ctrl_high_r),
    .dec         (dec)
  );

  // Low bits of the word address serve the smaller banks
  assign ram_en    = adv || clr_r;
  assign ram_be    = clr_r ? 4'b1111 : dec.be;
  assign ram_wdata = clr_r ? 32'd0 : dec.wdata;
  assign ram_addr  = clr_r ? clr_addr_r : addr1_r[16:2];

  // Bank RAMs: one per bank so that overlapping hits are served together
  for (genvar b = vrbm_pkg::BANK_A; b <= vrbm_pkg::BANK_D; b++) begin : g_large
    vrbm_ram #(.WIDTH(vrbm_pkg::DATA_W), .DEPTH(vrbm_pkg::DEPTH_LARGE)) u_ram (
      .clk   (clk),
      .en    (ram_en),
      .we    (clr_r || (dec.hits[b] && cmd1_r)),
      .be    (ram_be),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (rd[b])
    );
  end

  vrbm_ram #(.WIDTH(vrbm_pkg::DATA_W), .DEPTH(vrbm_pkg::DEPTH_E)) u_ram_e (
    .clk   (clk),
    .en    (ram_en),
    .we    (clr_r || (dec.hits[vrbm_pkg::BANK_E] && cmd1_r)),
    .be    (ram_be),
    .addr  (ram_addr[13:0]),
    .wdata (ram_wdata),
    .rdata (rd[vrbm_pkg::BANK_E])
  );

  for (genvar b = vrbm_pkg::BANK_F; b <= vrbm_pkg::BANK_G; b++) begin : g_fg
    vrbm_ram #(.WIDTH(vrbm_pkg::DATA_W), .DEPTH(vrbm_pkg::DEPTH_SMALL)) u_ram (
      .clk   (clk),
      .en    (ram_en),
      .we    (clr_r || (dec.hits[b] && cmd1_r)),
      .be    (ram_be),
      .addr  (ram_addr[11:0]),
      .wdata (ram_wdata),
      .rdata (rd[b])
    );
  end

  vrbm_ram #(.WIDTH(vrbm_pkg::DATA_W), .DEPTH(vrbm_pkg::DEPTH_H)) u_ram_h (
    .clk   (clk),
    .en    (ram_en),
    .we    (clr_r || (dec.hits[vrbm_pkg::BANK_H] && cmd1_r)),
    .be    (ram_be),
    .addr  (ram_addr[12:0]),
    .wdata (ram_wdata),
    .rdata (rd[vrbm_pkg::BANK_H])
  );

  vrbm_ram #(.WIDTH(vrbm_pkg::DATA_W), .DEPTH(vrbm_pkg::DEPTH_SMALL)) u_ram_i (
    .clk   (clk),
    .en    (ram_en),
    .we    (clr_r || (dec.hits[vrbm_pkg::BANK_I] && cmd1_r)),
    .be    (ram_be),
    .addr  (ram_addr[11:0]),
    .wdata (ram_wdata),
    .rdata (rd[vrbm_pkg::BANK_I])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (!v2_r || !out_stall) begin
      v2_r <= adv;
    end
  end

  // Hold the sideband while the result waits; it moves only with the RAMs
  always_ff @(posedge clk) begin
    if (adv) begin
      wr2_r     <= cmd1_r;
      size2_r   <= size1_r;
      lane2_r   <= addr1_r[1:0];
      hits2_r   <= dec.hits;
      status2_r <= dec.status;
      err2_r    <= dec.err;
    end
  end

  // Merge every hit bank, then pick the lanes of the access
  always_comb begin
    rd_or = '0;
    for (int b = 0; b < vrbm_pkg::NUM_BANKS; b++) begin
      if (hits2_r[b]) rd_or = rd_or | rd[b];
    end
    case (size2_r)
      vrbm_pkg::SIZE_BYTE: rd_sh = {24'd0, 8'(rd_or >> {lane2_r, 3'b000})};
      vrbm_pkg::SIZE_HALF: rd_sh = {16'd0, 16'(rd_or >> {lane2_r[1], 4'b0000})};
      default:             rd_sh = rd_or;
    endcase
  end

  assign out_valid       = v2_r;
  assign out_read_data   = (wr2_r == vrbm_pkg::CMD_WRITE) ? 32'd0 : rd_sh;
  assign out_bank_hits   = hits2_r;
  assign out_vram_status = status2_r;
  assign out_error_code  = err2_r;

endmodule

### design/vrbm_checker.sv
module vrbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic [8:0]  out_bank_hits,
  input logic [1:0]  out_error_code
);

  // A waiting result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Any error leaves the bank mask empty
  a_err_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != vrbm_pkg::ERR_OK |-> out_bank_hits == 9'd0)
    else $error("banks touched on an error");

  // Errors and misses read as zero
  a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bank_hits == 9'd0 |-> out_read_data == 32'd0)
    else $error("read data without a bank hit");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind video_ram_bank_mapper_unit vrbm_checker u_vrbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_bank_hits  (out_bank_hits),
  .out_error_code (out_error_code)
);

### tb/vram_mapper_checker.sv
`timescale 1ns / 1ps
module vram_mapper_checker #(
  parameter logic [3:0] CTRL_LOW_ADDR  = 4'h0,
  parameter logic [3:0] CTRL_HIGH_ADDR = 4'h8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [1:0]  in_access_size,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic        in_arm7_window,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_read_data,
  input  logic [8:0]  out_bank_hits,
  input  logic [1:0]  out_vram_status,
  input  logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          mismatches
);
  import vrbm_pkg::*;

  typedef struct packed {
    logic [31:0] rdata;
    logic [8:0]  hits;
    logic [1:0]  status;
    logic [1:0]  err;
  } access_result_t;

  logic [31:0] ctrl_low;
  logic [39:0] ctrl_high;
  bit [31:0]   bank_words[int];
  access_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [7:0] ctrl_byte(int b);
    return (b < 4) ? ctrl_low[8*b +: 8] : ctrl_high[8*(b-4) +: 8];
  endfunction

  function automatic logic usable(int b, logic [2:0] mst);
    logic [7:0] c;
    c = ctrl_byte(b);
    return c[7] && c[2:0] == mst;
  endfunction

  function automatic logic [31:0] bank_bytes(int b);
    if (b < BANK_E) return 32'h20000;
    if (b == BANK_E) return 32'h10000;
    if (b == BANK_H) return 32'h8000;
    return 32'h4000;
  endfunction

  function automatic logic placed(int b, logic [31:0] base, logic [31:0] a);
    return (a & ~(bank_bytes(b) - 1)) == base;
  endfunction

  function automatic logic [31:0] fg_base(logic [31:0] base, logic [1:0] ofs);
    return base + 32'h10000 * ofs[1] + 32'h4000 * ofs[0];
  endfunction

  function automatic access_result_t predict_access(logic cmd, logic [1:0] sz,
      logic [31:0] a, logic [31:0] wd, logic a7);
    access_result_t r;
    logic [31:0] m, rd, base;
    logic [8:0]  hits;
    logic [1:0]  ofs;
    logic [7:0]  c;
    int sh, slot, key, b;
    hits = '0;
    rd = '0;
    r.err = ERR_OK;
    if (sz == SIZE_BYTE) begin
      m = 32'hFF; sh = 8 * a[1:0];
    end else if (sz == SIZE_HALF) begin
      m = 32'hFFFF; sh = 16 * a[1];
    end else begin
      m = 32'hFFFF_FFFF; sh = 0;
    end
    if (a7) begin
      if (cmd == CMD_WRITE) r.err = ERR_ARM7_WRITE;
      else
        for (b = BANK_C; b <= BANK_D; b++) begin
          c = ctrl_byte(b);
          if (c[7] && c[4:3] == {1'b0, a[17]}) hits[b] = 1'b1;
        end
    end else if (a[31:21] == REGION_BG_A) begin
      for (b = BANK_A; b <= BANK_G; b++) begin
        c = ctrl_byte(b);
        ofs = c[4:3];
        base = 32'h0600_0000;
        if (b < BANK_E) base += 32'h20000 * ofs;
        else if (b > BANK_E) base = fg_base(32'h0600_0000, ofs);
        if (usable(b, MST_BG) && placed(b, base, a)) hits[b] = 1'b1;
      end
    end else if (a[31:21] == REGION_BG_B) begin
      hits[BANK_C] = usable(BANK_C, MST_ALT) && placed(BANK_C, 32'h0620_0000, a);
      hits[BANK_H] = usable(BANK_H, MST_BG) && placed(BANK_H, 32'h0620_0000, a);
      hits[BANK_I] = usable(BANK_I, MST_BG) && placed(BANK_I, 32'h0620_8000, a);
    end else if (a[31:21] == REGION_OBJ_A) begin
      for (b = BANK_A; b <= BANK_G; b++) begin
        c = ctrl_byte(b);
        ofs = c[4:3];
        base = 32'h0640_0000;
        if (b == BANK_C || b == BANK_D) continue;
        if (b < BANK_C) base += 32'h20000 * ofs[0];
        else if (b > BANK_E) base = fg_base(32'h0640_0000, ofs);
        if (usable(b, MST_OBJ) && placed(b, base, a)) hits[b] = 1'b1;
      end
    end else if (a[31:21] == REGION_OBJ_B) begin
      hits[BANK_D] = usable(BANK_D, MST_ALT) && placed(BANK_D, 32'h0660_0000, a);
      hits[BANK_I] = usable(BANK_I, MST_OBJ) && placed(BANK_I, 32'h0660_0000, a);
    end else if (a >= 32'h0680_0000 && a < 32'h068A_4000) begin
      slot = (a - 32'h0680_0000) >> 14;
      if (slot < 32) b = slot >> 3;
      else if (slot < 36) b = BANK_E;
      else if (slot == 36) b = BANK_F;
      else if (slot == 37) b = BANK_G;
      else if (slot < 40) b = BANK_H;
      else b = BANK_I;
      c = ctrl_byte(b);
      hits[b] = c[7];
    end else begin
      r.err = ERR_UNMAPPED;
    end
    for (b = 0; b < NUM_BANKS; b++) begin
      if (!hits[b]) continue;
      key = b * 32768 + ((a & (bank_bytes(b) - 1)) >> 2);
      if (cmd == CMD_WRITE)
        bank_words[key] = (bank_words.exists(key) ? bank_words[key] : 32'h0)
                          & ~(m << sh) | ((wd & m) << sh);
      else if (bank_words.exists(key))
        rd |= bank_words[key];
    end
    r.rdata  = (cmd == CMD_WRITE) ? 32'h0 : ((rd >> sh) & m);
    r.hits   = hits;
    r.status = {usable(BANK_D, MST_OBJ), usable(BANK_C, MST_OBJ)};
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t got, exp_r;
    if (!rst_n) begin
      ctrl_low  <= '0;
      ctrl_high <= '0;
      mismatches <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == CTRL_LOW_ADDR) ctrl_low <= pwdata[31:0];
        else if (paddr == CTRL_HIGH_ADDR) ctrl_high <= pwdata[39:0];
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_access(in_cmd, in_access_size,
            in_address, in_write_data, in_arm7_window));
      if (out_valid && !out_stall) begin
        got = '{out_read_data, out_bank_hits, out_vram_status, out_error_code};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display({"%0t: mismatch rdata exp %h got %h, hits exp %h got %h,",
                      " status exp %h got %h, err exp %h got %h"},
                     $time, exp_r.rdata, got.rdata, exp_r.hits, got.hits,
                     exp_r.status, got.status, exp_r.err, got.err);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

### tb/video_ram_bank_mapper_unit_test.sv
`timescale 1ns / 1ps
module video_ram_bank_mapper_unit_test;
  import vrbm_pkg::*;

  localparam logic [3:0] CTRL_LOW_ADDR  = 4'h0;
  localparam logic [3:0] CTRL_HIGH_ADDR = 4'h8;
  localparam logic [1:0] SIZE_WORD      = 2'd2;
  localparam logic [1:0] SIZE_ODD       = 2'd3;
  localparam int         IDLE_LIMIT     = 100000;
  localparam int         NUM_PHASES     = 9;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = CMD_READ;
  logic [1:0]  in_access_size = SIZE_BYTE;
  logic [31:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic        in_arm7_window = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_data;
  logic [8:0]  out_bank_hits;
  logic [1:0]  out_vram_status;
  logic [1:0]  out_error_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          pending;
  int          mismatches;
  int          idle_cycles = 0;
  bit          sender_gaps = 1'b1;
  bit          receiver_gaps = 1'b1;
  // addresses written since the last register change; safe to read back
  logic [31:0] fresh_addrs[$];

  always #2 clk = ~clk;

  video_ram_bank_mapper_unit dut (.*);

  vram_mapper_checker #(.CTRL_LOW_ADDR(CTRL_LOW_ADDR), .CTRL_HIGH_ADDR(CTRL_HIGH_ADDR))
    checker_i (.*);

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: alternate stall bursts with quiet stretches
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = receiver_gaps ? gap_len() : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      if ($urandom_range(0, 49) == 0) receiver_gaps = !receiver_gaps;
    end
  end

  // Hand one request to the block; returns after it is taken
  task automatic send_request(logic cmd, logic [1:0] sz, logic [31:0] a,
                              logic [31:0] wd, logic a7);
    int n;
    n = sender_gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_access_size <= sz;
    in_address     <= a;
    in_write_data  <= wd;
    in_arm7_window <= a7;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
    if (cmd == CMD_WRITE && !a7) fresh_addrs.push_back(a);
    if (fresh_addrs.size() > 32) void'(fresh_addrs.pop_front());
    if ($urandom_range(0, 59) == 0) sender_gaps = !sender_gaps;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (6) @(negedge clk);
  endtask

  // Register writes only with the pipeline empty
  task automatic write_ctrl(logic [31:0] low, logic [39:0] high);
    logic [3:0]  addrs[2];
    logic [63:0] vals[2];
    addrs = '{CTRL_LOW_ADDR, CTRL_HIGH_ADDR};
    vals  = '{{32'h0, low}, {24'h0, high}};
    drain();
    for (int i = 0; i < 2; i++) begin
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= addrs[i]; pwdata <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      @(negedge clk);
    end
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    fresh_addrs.delete();
  endtask

  function automatic logic [7:0] random_ctrl();
    logic [2:0] msts[5] = '{3'd0, MST_BG, MST_OBJ, MST_ALT, 3'd0};
    logic [7:0] c;
    c = 8'($urandom);
    c[7] = $urandom_range(0, 4) != 0;
    c[2:0] = ($urandom_range(0, 4) == 4) ? c[2:0] : msts[$urandom_range(0, 3)];
    return c;
  endfunction

  // Mostly addresses near the decoded windows, some anywhere on the bus
  function automatic logic [31:0] random_addr();
    logic [31:0] bases[5] = '{32'h0600_0000, 32'h0620_0000, 32'h0640_0000,
                              32'h0660_0000, 32'h0680_0000};
    int k;
    k = $urandom_range(0, 11);
    if (k < 5) return bases[k] + $urandom_range(0, 32'h7FFFF);
    if (k < 9) return 32'h0680_0000 + $urandom_range(0, 32'hA4000);
    if (k < 11) return {11'($urandom_range(32'h30, 32'h35)), 21'($urandom)};
    return $urandom;
  endfunction

  initial begin
    logic [31:0] a, low;
    logic [39:0] high;
    logic        cmd, a7;
    logic [1:0]  sz;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Preload: the first word of every 16 KB slot of every bank goes in
    // through the linear window, so later reads with address bits 13:2 clear
    // are safe
    write_ctrl(32'h8080_8080, 40'h80_8080_8080);
    for (int slot = 0; slot < 41; slot++)
      send_request(CMD_WRITE, SIZE_WORD, 32'h0680_0000 + slot * 32'h4000,
                   $urandom, 1'b0);

    // Directed: banks A/B background, C/D object (status), E object, F..I background
    write_ctrl(32'h8A_8A_91_81, 40'h81_81_89_81_82);
    send_request(CMD_WRITE, SIZE_BYTE, 32'h0600_0003, 32'hFFFF_FFA5, 1'b0);
    send_request(CMD_READ, SIZE_BYTE, 32'h0600_0003, 32'h0, 1'b0);
    send_request(CMD_WRITE, SIZE_HALF, 32'h0602_1002, 32'h1234_BEEF, 1'b0);
    send_request(CMD_READ, SIZE_HALF, 32'h0602_1003, 32'h0, 1'b0);
    send_request(CMD_WRITE, SIZE_ODD, 32'h0640_0010, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_READ, SIZE_WORD, 32'h0640_0012, 32'h0, 1'b0);
    send_request(CMD_WRITE, SIZE_WORD, 32'h0620_8004, 32'h0, 1'b0);
    send_request(CMD_READ, SIZE_WORD, 32'h0620_8004, 32'h0, 1'b0);
    send_request(CMD_READ, SIZE_ODD, 32'h0620_0000, 32'h0, 1'b0);
    send_request(CMD_READ, SIZE_WORD, 32'h0660_0000, 32'h0, 1'b0);
    send_request(CMD_WRITE, SIZE_WORD, 32'h068A_3FFC, 32'hCAFE_F00D, 1'b0);
    send_request(CMD_READ, SIZE_WORD, 32'h068A_3FFC, 32'h0, 1'b0);
    send_request(CMD_READ, SIZE_WORD, 32'h068A_4000, 32'h0, 1'b0);
    send_request(CMD_READ, SIZE_BYTE, 32'h0000_0000, 32'h0, 1'b0);
    send_request(CMD_WRITE, SIZE_WORD, 32'hFFFF_FFFF, 32'h5555_5555, 1'b0);
    send_request(CMD_WRITE, SIZE_WORD, 32'h0600_0000, 32'h1, 1'b1);
    send_request(CMD_READ, SIZE_WORD, 32'h0000_0000, 32'h0, 1'b1);
    send_request(CMD_READ, SIZE_HALF, 32'hFFFE_00FE, 32'h0, 1'b1);

    // Pause until every result is back before going on
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0) begin
        low = '1; high = '1;
      end else if (phase == 1) begin
        low = '0; high = '0;
      end else begin
        for (int b = 0; b < 4; b++) low[8*b +: 8] = random_ctrl();
        for (int b = 0; b < 5; b++) high[8*b +: 8] = random_ctrl();
      end
      write_ctrl(low, high);
      for (int i = 0; i < 90; i++) begin
        cmd = $urandom_range(0, 2) == 0;
        sz  = 2'($urandom_range(0, 3));
        a7  = $urandom_range(0, 9) == 0;
        a   = random_addr();
        if (cmd == CMD_READ) begin
          // either a location written under this setting or a preloaded one
          if (fresh_addrs.size() > 0 && $urandom_range(0, 2) == 0 && !a7)
            a = fresh_addrs[$urandom_range(0, fresh_addrs.size() - 1)];
          else
            a = a & ~32'h3FFC;
        end
        send_request(cmd, sz, a, $urandom, a7);
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
